### rtl/core/rcd_pkg.sv
package rcd_pkg;

  // Width of the link loss counter.
  localparam int CNT_BITS = 16;
  // Width of the offline limit register.
  localparam int LIMIT_BITS = 16;
  // Common width for comparing the counter against the limit.
  localparam int CMP_BITS = (CNT_BITS > LIMIT_BITS) ? CNT_BITS : LIMIT_BITS;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd100;
  localparam int STORE_DEPTH = 10;
  localparam logic [4:0] POS_MAX = 5'd31;
  localparam logic [4:0] POS_BYTE23 = 5'd23;
  localparam logic [7:0] BYTE23_FAILSAFE = 8'd16;
  localparam logic [11:0] STICK_OFFSET = 12'd1000;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_CTRL = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    EV_KEEP = 2'd0,
    EV_UP   = 2'd1,
    EV_MID  = 2'd2,
    EV_DOWN = 2'd3
  } ev_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] byte_value;
    logic       frame_end;
  } item_t;

  typedef struct packed {
    logic signed [11:0] stick_0;
    logic signed [11:0] stick_1;
    logic signed [11:0] stick_2;
    logic signed [11:0] stick_3;
    logic [2:0]         left_switch_position;
    logic [2:0]         right_switch_position;
    logic [1:0]         left_switch_event;
    logic [1:0]         right_switch_event;
    logic               link_online;
  } result_t;

  // Raw 11-bit switch value divided by 500, for values up to 2047.
  function automatic logic [2:0] switch_pos(input logic [10:0] raw);
    logic [2:0] pos;
    if (raw >= 11'd2000) begin
      pos = 3'd4;
    end else if (raw >= 11'd1500) begin
      pos = 3'd3;
    end else if (raw >= 11'd1000) begin
      pos = 3'd2;
    end else if (raw >= 11'd500) begin
      pos = 3'd1;
    end else begin
      pos = 3'd0;
    end
    return pos;
  endfunction

  function automatic logic [11:0] stick_val(input logic [10:0] raw);
    return {1'b0, raw} - STICK_OFFSET;
  endfunction

endpackage

### rtl/core/rcd_in_if.sv
interface rcd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] byte_value;
  logic       frame_end;

  modport source (output valid, output operation, output byte_value, output frame_end,
                  input ready);
  modport sink (input valid, input operation, input byte_value, input frame_end,
                output ready);
endinterface

### rtl/core/rcd_out_if.sv
interface rcd_out_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] stick_0;
  logic signed [11:0] stick_1;
  logic signed [11:0] stick_2;
  logic signed [11:0] stick_3;
  logic [2:0]         left_switch_position;
  logic [2:0]         right_switch_position;
  logic [1:0]         left_switch_event;
  logic [1:0]         right_switch_event;
  logic               link_online;

  modport source (output valid, output stick_0, output stick_1, output stick_2,
                  output stick_3, output left_switch_position,
                  output right_switch_position, output left_switch_event,
                  output right_switch_event, output link_online, input ready);
  modport sink (input valid, input stick_0, input stick_1, input stick_2,
                input stick_3, input left_switch_position,
                input right_switch_position, input left_switch_event,
                input right_switch_event, input link_online, output ready);
endinterface

### rtl/core/rcd_cfg_if.sv
interface rcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] offline_limit;

  modport source (output valid, output offline_limit, input ready);
  modport sink (input valid, input offline_limit, output ready);
endinterface

### rtl/core/rcd_in_reg.sv
module rcd_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  rcd_pkg::item_t in_item,
  output logic          in_ready,
  input  logic          take,
  output logic          item_valid,
  output rcd_pkg::item_t item
);

  logic           valid_r;
  rcd_pkg::item_t item_r;
  logic           load;

  assign in_ready   = !valid_r || take;
  assign load       = in_valid && in_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  // A held item that the core did not take must still be there next cycle.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !take |=> valid_r && $stable(item_r))
    else $error("rcd_in_reg: held item lost or changed");

  a_no_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r |-> in_ready)
    else $error("rcd_in_reg: empty stage refuses an item");

  a_load_sets: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r)
    else $error("rcd_in_reg: loaded item not marked valid");

endmodule

### rtl/core/rcd_unpack.sv
module rcd_unpack (
  input  logic [7:0]  bytes [rcd_pkg::STORE_DEPTH],
  output logic [11:0] sticks [4],
  output logic [2:0]  switches [2]
);

  logic [10:0] raw_stick [4];
  logic [10:0] raw_sw [2];

  // Channels are packed LSB first, 11 bits each, starting at byte 1.
  always_comb begin
    raw_stick[0] = {bytes[2][2:0], bytes[1]};
    raw_stick[1] = {bytes[3][5:0], bytes[2][7:3]};
    raw_stick[2] = {bytes[5][0], bytes[4], bytes[3][7:6]};
    raw_stick[3] = {bytes[6][3:0], bytes[5][7:1]};
    raw_sw[0]    = {bytes[7][6:0], bytes[6][7:4]};
    raw_sw[1]    = {bytes[9][1:0], bytes[8], bytes[7][7]};
    for (int i = 0; i < 4; i++) begin
      sticks[i] = rcd_pkg::stick_val(raw_stick[i]);
    end
    for (int i = 0; i < 2; i++) begin
      switches[i] = rcd_pkg::switch_pos(raw_sw[i]);
    end
  end

endmodule

### rtl/core/rcd_core.sv
module rcd_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  input  rcd_pkg::item_t  item,
  output logic            take,
  input  logic            cfg_valid,
  input  logic [15:0]     cfg_data,
  output logic            cfg_ready,
  output logic            res_valid,
  output rcd_pkg::result_t res,
  input  logic            res_ready
);

  logic [rcd_pkg::LIMIT_BITS-1:0] limit_r;
  logic [4:0]  pos_r, pos_nxt;
  logic [7:0]  store_r [rcd_pkg::STORE_DEPTH];
  logic [7:0]  b23_r, b23_nxt;
  logic [11:0] stick_r [4];
  logic [11:0] stick_nxt [4];
  logic [2:0]  sw_val_r [2];
  logic [2:0]  sw_val_nxt [2];
  logic [2:0]  sw_prev_r [2];
  logic [2:0]  sw_prev_nxt [2];
  rcd_pkg::ev_t sw_ev_r [2];
  rcd_pkg::ev_t sw_ev_nxt [2];
  logic [rcd_pkg::CNT_BITS-1:0] loss_r, loss_nxt, loss_inc;
  logic        online_r, online_nxt;
  logic        pending_r, pending_nxt;
  logic        prev_online_r, prev_online_nxt;
  logic        out_valid_r;
  rcd_pkg::result_t res_r, res_nxt;

  logic        fire;
  logic        byte_wr;
  logic        lost;
  rcd_pkg::op_t op;
  logic [7:0]  frame_bytes [rcd_pkg::STORE_DEPTH];
  logic [11:0] dec_sticks [4];
  logic [2:0]  dec_sw [2];

  assign take      = !out_valid_r || res_ready;
  assign fire      = item_valid && take;
  assign cfg_ready = 1'b1;
  assign op        = rcd_pkg::op_t'(item.operation);
  assign byte_wr   = (op == rcd_pkg::OP_BYTE);
  assign loss_inc  = loss_r + rcd_pkg::CNT_BITS'(1);
  assign lost      = rcd_pkg::CMP_BITS'(loss_inc) > rcd_pkg::CMP_BITS'(limit_r);
  assign res_valid = out_valid_r;
  assign res       = res_r;

  // The byte carrying the frame end is part of the frame it closes.
  always_comb begin
    for (int i = 0; i < rcd_pkg::STORE_DEPTH; i++) begin
      frame_bytes[i] = (pos_r == 5'(i)) ? item.byte_value : store_r[i];
    end
  end

  rcd_unpack u_unpack (
    .bytes    (frame_bytes),
    .sticks   (dec_sticks),
    .switches (dec_sw)
  );

  always_comb begin
    pos_nxt         = pos_r;
    b23_nxt         = b23_r;
    stick_nxt       = stick_r;
    sw_val_nxt      = sw_val_r;
    sw_prev_nxt     = sw_prev_r;
    sw_ev_nxt       = sw_ev_r;
    loss_nxt        = loss_r;
    online_nxt      = online_r;
    pending_nxt     = pending_r;
    prev_online_nxt = prev_online_r;
    unique case (op)
      rcd_pkg::OP_BYTE: begin
        if (pos_r == rcd_pkg::POS_BYTE23) begin
          b23_nxt = item.byte_value;
        end
        if (pos_r < rcd_pkg::POS_MAX) begin
          pos_nxt = pos_r + 5'd1;
        end
        if (item.frame_end) begin
          pos_nxt    = 5'd0;
          stick_nxt  = dec_sticks;
          sw_val_nxt = dec_sw;
          if (b23_nxt != rcd_pkg::BYTE23_FAILSAFE) begin
            pending_nxt = 1'b1;
            loss_nxt    = '0;
            online_nxt  = 1'b1;
          end
        end
      end
      rcd_pkg::OP_TICK: begin
        loss_nxt = loss_inc;
        if (lost) begin
          for (int i = 0; i < 4; i++) begin
            stick_nxt[i] = '0;
          end
          for (int i = 0; i < 2; i++) begin
            sw_val_nxt[i]  = '0;
            sw_prev_nxt[i] = '0;
            sw_ev_nxt[i]   = rcd_pkg::EV_KEEP;
          end
          loss_nxt    = rcd_pkg::CNT_BITS'(limit_r);
          online_nxt  = 1'b0;
          pending_nxt = 1'b0;
        end
      end
      rcd_pkg::OP_CTRL: begin
        if (pending_r) begin
          pending_nxt = 1'b0;
          if (prev_online_r == online_r) begin
            for (int i = 0; i < 2; i++) begin
              if (sw_val_r[i] != sw_prev_r[i]) begin
                // Positions 0 and 4 leave the last event in place.
                if (sw_val_r[i] >= 3'd1 && sw_val_r[i] <= 3'd3) begin
                  sw_ev_nxt[i] = rcd_pkg::ev_t'(sw_val_r[i][1:0]);
                end
                sw_prev_nxt[i] = sw_val_r[i];
              end else begin
                sw_ev_nxt[i] = rcd_pkg::EV_KEEP;
              end
            end
          end else begin
            sw_prev_nxt = sw_val_r;
          end
        end
        prev_online_nxt = online_r;
      end
      rcd_pkg::OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_nxt.stick_0               = stick_nxt[0];
    res_nxt.stick_1               = stick_nxt[1];
    res_nxt.stick_2               = stick_nxt[2];
    res_nxt.stick_3               = stick_nxt[3];
    res_nxt.left_switch_position  = sw_val_nxt[0];
    res_nxt.right_switch_position = sw_val_nxt[1];
    res_nxt.left_switch_event     = sw_ev_nxt[0];
    res_nxt.right_switch_event    = sw_ev_nxt[1];
    res_nxt.link_online           = online_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r       <= rcd_pkg::LIMIT_RESET;
      pos_r         <= '0;
      b23_r         <= '0;
      for (int i = 0; i < 4; i++) begin
        stick_r[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        sw_val_r[i]  <= '0;
        sw_prev_r[i] <= '0;
        sw_ev_r[i]   <= rcd_pkg::EV_KEEP;
      end
      loss_r        <= rcd_pkg::CNT_BITS'(rcd_pkg::LIMIT_RESET);
      online_r      <= 1'b0;
      pending_r     <= 1'b0;
      prev_online_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      if (fire) begin
        pos_r         <= pos_nxt;
        b23_r         <= b23_nxt;
        stick_r       <= stick_nxt;
        sw_val_r      <= sw_val_nxt;
        sw_prev_r     <= sw_prev_nxt;
        sw_ev_r       <= sw_ev_nxt;
        loss_r        <= loss_nxt;
        online_r      <= online_nxt;
        pending_r     <= pending_nxt;
        prev_online_r <= prev_online_nxt;
      end
      if (take) begin
        out_valid_r <= item_valid;
      end
    end
  end

  // Frame store has no reset: entries are undefined until written.
  always_ff @(posedge clk) begin
    if (fire && byte_wr) begin
      for (int i = 0; i < rcd_pkg::STORE_DEPTH; i++) begin
        if (pos_r == 5'(i)) begin
          store_r[i] <= item.byte_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  a_pending_online: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> online_r)
    else $error("rcd_core: update pending while link offline");

  a_loss_offline: assert property (@(posedge clk) disable iff (!rst_n)
    fire && op == rcd_pkg::OP_TICK && lost |=> !online_r && !pending_r)
    else $error("rcd_core: link loss did not drop the link");

  a_frame_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    fire && byte_wr && item.frame_end |=> pos_r == 5'd0)
    else $error("rcd_core: byte position not rewound at frame end");

  a_result_online: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> res_r.link_online == online_r)
    else $error("rcd_core: result link state differs from link state");

endmodule

### rtl/core/rc_frame_decoder_link_watchdog.sv
// Channel   Direction  Handshake        Payload
// in_ch     sink       valid / ready    operation, byte_value, frame_end
// out_ch    source     valid / ready    stick_0..3, switch positions and events, link_online
// cfg_ch    sink       valid / ready    offline_limit (always ready)
//
// Each accepted item yields one result item, held in the input register and then in the
// result register; one item per cycle is sustained while out_ch is ready.
// Reset is synchronous on rst_n low; the frame store keeps no reset value.
// When out_ch stalls, the result register holds and the input register takes one
// more item before in_ch.ready drops.
module rc_frame_decoder_link_watchdog (
  input  logic clk,
  input  logic rst_n,
  rcd_in_if.sink    in_ch,
  rcd_out_if.source out_ch,
  rcd_cfg_if.sink   cfg_ch
);

  rcd_pkg::item_t   in_item;
  rcd_pkg::item_t   item;
  rcd_pkg::result_t res;
  logic             item_valid;
  logic             take;
  logic             res_valid;

  always_comb begin
    in_item.operation  = in_ch.operation;
    in_item.byte_value = in_ch.byte_value;
    in_item.frame_end  = in_ch.frame_end;
  end

  rcd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_item    (in_item),
    .in_ready   (in_ch.ready),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  rcd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .cfg_valid  (cfg_ch.valid),
    .cfg_data   (cfg_ch.offline_limit),
    .cfg_ready  (cfg_ch.ready),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (out_ch.ready)
  );

  assign out_ch.valid                 = res_valid;
  assign out_ch.stick_0               = res.stick_0;
  assign out_ch.stick_1               = res.stick_1;
  assign out_ch.stick_2               = res.stick_2;
  assign out_ch.stick_3               = res.stick_3;
  assign out_ch.left_switch_position  = res.left_switch_position;
  assign out_ch.right_switch_position = res.right_switch_position;
  assign out_ch.left_switch_event     = res.left_switch_event;
  assign out_ch.right_switch_event    = res.right_switch_event;
  assign out_ch.link_online           = res.link_online;

endmodule

### tb/sv/rc_frame_decoder_link_watchdog_test.sv
`timescale 1ns / 100ps

module rc_frame_decoder_link_watchdog_test;

  localparam logic [10:0] SWITCH_STEP = 11'd500;
  localparam int MAX_REPORTS = 10;
  localparam int HOLD_OFF_CYCLES = 60;

  logic clk;
  logic rst_n;

  rcd_in_if  in_ch ();
  rcd_out_if out_ch ();
  rcd_cfg_if cfg_ch ();

  rc_frame_decoder_link_watchdog u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Decoder state as the testbench tracks it.
  logic [4:0]  dec_pos;
  logic [7:0]  dec_store [rcd_pkg::STORE_DEPTH];
  logic [7:0]  dec_byte23;
  logic [11:0] dec_stick [4];
  logic [2:0]  dec_sw [2];
  logic [2:0]  dec_sw_prev [2];
  logic [1:0]  dec_sw_ev [2];
  logic [rcd_pkg::CNT_BITS-1:0]   dec_loss;
  logic        dec_online;
  logic        dec_update;
  logic        dec_prev_online;
  logic [rcd_pkg::LIMIT_BITS-1:0] dec_limit;
  bit          store_ready;

  rcd_pkg::result_t pending_readouts [$];
  logic [7:0]  last_switch_bytes [4];
  int          mismatch_count = 0;
  int          sent_items = 0;
  bit          sender_idles = 1'b1;
  bit          receiver_idles = 1'b1;
  int          hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("rc_frame_decoder_link_watchdog verification failed");
    $finish;
  end

  task automatic clear_link();
    for (int i = 0; i < 4; i++) begin
      dec_stick[i] = '0;
    end
    for (int i = 0; i < 2; i++) begin
      dec_sw[i] = '0;
      dec_sw_prev[i] = '0;
      dec_sw_ev[i] = rcd_pkg::EV_KEEP;
    end
    dec_loss = rcd_pkg::CNT_BITS'(dec_limit);
    dec_online = 1'b0;
    dec_update = 1'b0;
  endtask

  task automatic reset_decoder();
    dec_pos = '0;
    for (int i = 0; i < rcd_pkg::STORE_DEPTH; i++) begin
      dec_store[i] = '0;
    end
    dec_byte23 = '0;
    dec_limit = rcd_pkg::LIMIT_RESET;
    dec_prev_online = 1'b0;
    store_ready = 1'b0;
    clear_link();
  endtask

  task automatic update_switch(input int s);
    if (dec_sw[s] != dec_sw_prev[s]) begin
      // Positions 0 and 4 have no event code, so the old event stays.
      if (dec_sw[s] >= 3'(rcd_pkg::EV_UP) && dec_sw[s] <= 3'(rcd_pkg::EV_DOWN)) begin
        dec_sw_ev[s] = dec_sw[s][1:0];
      end
      dec_sw_prev[s] = dec_sw[s];
    end else begin
      dec_sw_ev[s] = rcd_pkg::EV_KEEP;
    end
  endtask

  task automatic advance_decoder(input logic [1:0] op, input logic [7:0] bv, input logic fe);
    rcd_pkg::result_t r;
    logic [10:0]      raw;
    unique case (rcd_pkg::op_t'(op))
      rcd_pkg::OP_BYTE: begin
        if (dec_pos < 5'(rcd_pkg::STORE_DEPTH)) begin
          dec_store[dec_pos[3:0]] = bv;
        end
        if (dec_pos == 5'(rcd_pkg::STORE_DEPTH - 1)) begin
          store_ready = 1'b1;
        end
        if (dec_pos == rcd_pkg::POS_BYTE23) begin
          dec_byte23 = bv;
        end
        if (dec_pos < rcd_pkg::POS_MAX) begin
          dec_pos = dec_pos + 5'd1;
        end
        if (fe) begin
          dec_stick[0] = {1'b0, dec_store[2][2:0], dec_store[1]}
                         - rcd_pkg::STICK_OFFSET;
          dec_stick[1] = {1'b0, dec_store[3][5:0], dec_store[2][7:3]}
                         - rcd_pkg::STICK_OFFSET;
          dec_stick[2] = {1'b0, dec_store[5][0], dec_store[4], dec_store[3][7:6]}
                         - rcd_pkg::STICK_OFFSET;
          dec_stick[3] = {1'b0, dec_store[6][3:0], dec_store[5][7:1]}
                         - rcd_pkg::STICK_OFFSET;
          raw = {dec_store[7][6:0], dec_store[6][7:4]};
          dec_sw[0] = 3'(raw / SWITCH_STEP);
          raw = {dec_store[9][1:0], dec_store[8], dec_store[7][7]};
          dec_sw[1] = 3'(raw / SWITCH_STEP);
          if (dec_byte23 != rcd_pkg::BYTE23_FAILSAFE) begin
            dec_update = 1'b1;
            dec_loss = '0;
            dec_online = 1'b1;
          end
          dec_pos = '0;
        end
      end
      rcd_pkg::OP_TICK: begin
        dec_loss = dec_loss + rcd_pkg::CNT_BITS'(1);
        if (rcd_pkg::CMP_BITS'(dec_loss) > rcd_pkg::CMP_BITS'(dec_limit)) begin
          clear_link();
        end
      end
      rcd_pkg::OP_CTRL: begin
        if (dec_update) begin
          dec_update = 1'b0;
          if (dec_prev_online == dec_online) begin
            update_switch(0);
            update_switch(1);
          end else begin
            // The link state changed, so only re-arm the previous positions.
            dec_sw_prev[0] = dec_sw[0];
            dec_sw_prev[1] = dec_sw[1];
          end
        end
        dec_prev_online = dec_online;
      end
      default: begin
      end
    endcase
    r.stick_0 = dec_stick[0];
    r.stick_1 = dec_stick[1];
    r.stick_2 = dec_stick[2];
    r.stick_3 = dec_stick[3];
    r.left_switch_position = dec_sw[0];
    r.right_switch_position = dec_sw[1];
    r.left_switch_event = dec_sw_ev[0];
    r.right_switch_event = dec_sw_ev[1];
    r.link_online = dec_online;
    pending_readouts.push_back(r);
  endtask

  task automatic send_item(input logic [1:0] op, input logic [7:0] bv, input logic fe);
    logic fe_eff;
    fe_eff = fe;
    // A frame may not end before every stored byte has been written once.
    if (op == rcd_pkg::OP_BYTE && fe && !store_ready &&
        dec_pos != 5'(rcd_pkg::STORE_DEPTH - 1)) begin
      fe_eff = 1'b0;
    end
    while (sender_idles && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.byte_value <= bv;
    in_ch.frame_end <= fe_eff;
    do @(posedge clk); while (!in_ch.ready);
    advance_decoder(op, bv, fe_eff);
    sent_items++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.offline_limit <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    dec_limit = value;
  endtask

  task automatic send_random_frame();
    int         len;
    int         pick;
    bit         repeat_switches;
    logic [7:0] value;
    pick = $urandom_range(99);
    if (pick < 55) begin
      len = 25;
    end else if (pick < 65) begin
      len = 24;
    end else if (pick < 80) begin
      len = $urandom_range(10, 23);
    end else if (pick < 92) begin
      len = $urandom_range(26, 40);
    end else begin
      len = $urandom_range(1, 9);
    end
    // Reusing the switch bytes of the last frame gives unchanged positions.
    repeat_switches = ($urandom_range(99) < 35);
    for (int i = 0; i < len; i++) begin
      value = 8'($urandom);
      if (i == 0 && $urandom_range(3) != 0) begin
        value = 8'h0F;
      end else if (i >= 6 && i <= 9) begin
        if (repeat_switches) begin
          value = last_switch_bytes[i - 6];
        end else begin
          last_switch_bytes[i - 6] = value;
        end
      end else if (i == int'(rcd_pkg::POS_BYTE23) && $urandom_range(99) < 20) begin
        value = rcd_pkg::BYTE23_FAILSAFE;
      end
      send_item(rcd_pkg::OP_BYTE, value, i == len - 1);
    end
  endtask

  task automatic random_traffic(input int count);
    int start;
    int pick;
    int burst;
    start = sent_items;
    while (sent_items - start < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_random_frame();
        if ($urandom_range(99) < 60) begin
          send_item(rcd_pkg::OP_CTRL, 8'($urandom), 1'($urandom_range(1)));
        end
      end else if (pick < 70) begin
        send_item(rcd_pkg::OP_CTRL, 8'($urandom), 1'($urandom_range(1)));
      end else if (pick < 85) begin
        if ($urandom_range(99) < 25 && dec_limit < 16'd120) begin
          burst = int'(dec_limit) + 2;
        end else begin
          burst = $urandom_range(1, 4);
        end
        repeat (burst) send_item(rcd_pkg::OP_TICK, 8'($urandom), 1'($urandom_range(1)));
      end else begin
        send_item(2'($urandom_range(3)), 8'($urandom), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_reset_state();
    // Operation 3 and a tick carrying frame_end both leave decoding alone.
    send_item(rcd_pkg::OP_NONE, 8'hA5, 1'b1);
    send_item(rcd_pkg::OP_TICK, 8'h5A, 1'b1);
  endtask

  task automatic test_full_scale_frame();
    for (int i = 0; i < rcd_pkg::STORE_DEPTH; i++) begin
      send_item(rcd_pkg::OP_BYTE, 8'hFF, i == rcd_pkg::STORE_DEPTH - 1);
    end
    send_item(rcd_pkg::OP_CTRL, 8'h00, 1'b1);
  endtask

  task automatic test_loss_at_zero_limit();
    write_limit(16'd0);
    send_item(rcd_pkg::OP_TICK, 8'h00, 1'b0);
    for (int i = 0; i < rcd_pkg::STORE_DEPTH; i++) begin
      send_item(rcd_pkg::OP_BYTE, 8'h00, i == rcd_pkg::STORE_DEPTH - 1);
    end
    send_item(rcd_pkg::OP_CTRL, 8'hFF, 1'b0);
  endtask

  task automatic test_short_limit();
    write_limit(16'd5);
    random_traffic(500);
  endtask

  task automatic test_backpressure();
    sender_idles = 1'b0;
    hold_cycles <= HOLD_OFF_CYCLES;
    repeat (40) send_item(rcd_pkg::OP_BYTE, 8'($urandom), $urandom_range(15) == 0);
    sender_idles = 1'b1;
  endtask

  task automatic test_zero_limit_traffic();
    write_limit(16'd0);
    random_traffic(250);
  endtask

  task automatic test_max_limit();
    write_limit(16'd65534);
    random_traffic(350);
  endtask

  task automatic test_no_idle_stretch();
    write_limit(16'($urandom_range(1, 20)));
    sender_idles = 1'b0;
    receiver_idles <= 1'b0;
    random_traffic(300);
    sender_idles = 1'b1;
    receiver_idles <= 1'b1;
  endtask

  task automatic test_default_limit();
    write_limit(rcd_pkg::LIMIT_RESET);
    random_traffic(500);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_ch.ready <= !(receiver_idles && $urandom_range(99) < 32);
      end
    end
  end

  task automatic check_field(input string name, input logic [11:0] want, input logic [11:0] got);
    if (want !== got) begin
      if (mismatch_count < MAX_REPORTS) begin
        $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    rcd_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_readouts.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) begin
          $display("result item with no prediction waiting");
        end
        mismatch_count++;
      end else begin
        want = pending_readouts.pop_front();
        check_field("stick_0", want.stick_0, out_ch.stick_0);
        check_field("stick_1", want.stick_1, out_ch.stick_1);
        check_field("stick_2", want.stick_2, out_ch.stick_2);
        check_field("stick_3", want.stick_3, out_ch.stick_3);
        check_field("left_switch_position", 12'(want.left_switch_position),
                    12'(out_ch.left_switch_position));
        check_field("right_switch_position", 12'(want.right_switch_position),
                    12'(out_ch.right_switch_position));
        check_field("left_switch_event", 12'(want.left_switch_event),
                    12'(out_ch.left_switch_event));
        check_field("right_switch_event", 12'(want.right_switch_event),
                    12'(out_ch.right_switch_event));
        check_field("link_online", 12'(want.link_online), 12'(out_ch.link_online));
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = rcd_pkg::OP_BYTE;
    in_ch.byte_value = '0;
    in_ch.frame_end = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.offline_limit = '0;
    for (int i = 0; i < 4; i++) begin
      last_switch_bytes[i] = '0;
    end
    reset_decoder();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_full_scale_frame();
    test_loss_at_zero_limit();
    test_short_limit();
    test_backpressure();
    test_zero_limit_traffic();
    test_max_limit();
    test_no_idle_stretch();
    test_default_limit();

    settle();
    if (mismatch_count == 0 && pending_readouts.size() == 0) begin
      $display("rc_frame_decoder_link_watchdog verification clean");
    end else begin
      $display("rc_frame_decoder_link_watchdog verification failed");
    end
    $finish;
  end

endmodule
